### src/telnet_option_parser_macros.svh
// Assertion macros for the telnet option parser.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TELNET_OPTION_PARSER_MACROS_SVH
`define TELNET_OPTION_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TNOP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TNOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tnop_pkg.sv
// Shared constants and types for the telnet option parser.
// No dependencies.
package tnop_pkg;

  localparam int SUB_DEPTH = 8;
  localparam int SUB_CNT_W = $clog2(SUB_DEPTH + 1);
  // Only the first five subnegotiation bytes can ever be read (NAWS report).
  localparam int NAWS_LEN  = 5;

  localparam logic [7:0] B_IAC    = 8'd255;
  localparam logic [7:0] B_DONT   = 8'd254;
  localparam logic [7:0] B_DO     = 8'd253;
  localparam logic [7:0] B_WILL   = 8'd251;
  localparam logic [7:0] B_SB     = 8'd250;
  localparam logic [7:0] B_SE     = 8'd240;
  localparam logic [7:0] OPT_NAWS = 8'd31;
  localparam logic [7:0] OPT_EXT  = 8'd200;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_IAC    = 3'd1;
  localparam logic [2:0] PH_OPT    = 3'd2;
  localparam logic [2:0] PH_SUB    = 3'd3;
  localparam logic [2:0] PH_SUBIAC = 3'd4;

  localparam logic [1:0] EXT_PENDING = 2'd0;
  localparam logic [1:0] EXT_ENABLED = 2'd1;
  localparam logic [1:0] EXT_REFUSED = 2'd2;

  typedef struct packed {
    logic        is_data;
    logic        send_do_naws;
    logic [1:0]  ext_status;
    logic        greet_request;
    logic        resized;
    logic [15:0] win_width;
    logic [15:0] win_height;
  } tnop_res_t;

endpackage

### src/tnop_core.sv
// Parser state and per-byte next-state logic of the telnet option parser.
// Depends on tnop_pkg and telnet_option_parser_macros.svh.
`include "telnet_option_parser_macros.svh"

module tnop_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output tnop_pkg::tnop_res_t res
);

  logic [2:0]                   phase_r, phase_nxt;
  logic [7:0]                   verb_r, verb_nxt;
  logic [tnop_pkg::SUB_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                   store_r   [tnop_pkg::NAWS_LEN];
  logic [7:0]                   store_nxt [tnop_pkg::NAWS_LEN];
  logic [15:0]                  width_r, width_nxt;
  logic [15:0]                  height_r, height_nxt;
  logic [1:0]                   ext_r, ext_nxt;
  logic                         greeted_r, greeted_nxt;
  logic                         naws, greet, resized, is_data;

  always_comb begin
    phase_nxt   = phase_r;
    verb_nxt    = verb_r;
    cnt_nxt     = cnt_r;
    store_nxt   = store_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    ext_nxt     = ext_r;
    greeted_nxt = greeted_r;
    naws        = 1'b0;
    greet       = 1'b0;
    resized     = 1'b0;
    is_data     = 1'b0;
    case (phase_r)
      tnop_pkg::PH_IAC: begin
        if (rx_byte >= tnop_pkg::B_WILL && rx_byte <= tnop_pkg::B_DONT) begin
          verb_nxt  = rx_byte;
          phase_nxt = tnop_pkg::PH_OPT;
        end else if (rx_byte == tnop_pkg::B_SB) begin
          cnt_nxt   = '0;
          phase_nxt = tnop_pkg::PH_SUB;
        end else begin
          phase_nxt = tnop_pkg::PH_IDLE;
        end
      end
      tnop_pkg::PH_OPT: begin
        if (rx_byte == tnop_pkg::OPT_NAWS) begin
          naws = 1'b1;
        end else if (rx_byte == tnop_pkg::OPT_EXT) begin
          if (verb_r == tnop_pkg::B_DO) begin
            ext_nxt = tnop_pkg::EXT_ENABLED;
            if (!greeted_r) begin
              greet       = 1'b1;
              greeted_nxt = 1'b1;
            end
          end else begin
            ext_nxt = tnop_pkg::EXT_REFUSED;
          end
        end
        phase_nxt = tnop_pkg::PH_IDLE;
      end
      tnop_pkg::PH_SUB: begin
        if (rx_byte == tnop_pkg::B_IAC) begin
          phase_nxt = tnop_pkg::PH_SUBIAC;
        end else if (cnt_r < tnop_pkg::SUB_CNT_W'(tnop_pkg::SUB_DEPTH)) begin
          // bytes past the NAWS report are counted but never read back
          for (int i = 0; i < tnop_pkg::NAWS_LEN; i++) begin
            if (cnt_r == tnop_pkg::SUB_CNT_W'(i)) begin
              store_nxt[i] = rx_byte;
            end
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tnop_pkg::PH_SUBIAC: begin
        if (rx_byte == tnop_pkg::B_SE) begin
          if (cnt_r >= tnop_pkg::SUB_CNT_W'(tnop_pkg::NAWS_LEN) &&
              store_r[0] == tnop_pkg::OPT_NAWS) begin
            width_nxt  = {store_r[1], store_r[2]};
            height_nxt = {store_r[3], store_r[4]};
            resized    = 1'b1;
          end
          phase_nxt = tnop_pkg::PH_IDLE;
        end else begin
          phase_nxt = tnop_pkg::PH_SUB;
        end
      end
      default: begin
        if (rx_byte == tnop_pkg::B_IAC) begin
          phase_nxt = tnop_pkg::PH_IAC;
        end else begin
          is_data = 1'b1;
        end
      end
    endcase
  end

  assign res.is_data       = is_data;
  assign res.send_do_naws  = naws;
  assign res.ext_status    = ext_nxt;
  assign res.greet_request = greet;
  assign res.resized       = resized;
  assign res.win_width     = width_nxt;
  assign res.win_height    = height_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= tnop_pkg::PH_IDLE;
      verb_r    <= '0;
      cnt_r     <= '0;
      width_r   <= '0;
      height_r  <= '0;
      ext_r     <= tnop_pkg::EXT_PENDING;
      greeted_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      verb_r    <= verb_nxt;
      cnt_r     <= cnt_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      ext_r     <= ext_nxt;
      greeted_r <= greeted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      store_r <= store_nxt;
    end
  end

  `TNOP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= tnop_pkg::SUB_CNT_W'(tnop_pkg::SUB_DEPTH), "sub count past depth")
  `TNOP_ASSERT_NOW(a_data_alone, is_data, !naws && !greet && !resized, "data beat raised a command flag")
  `TNOP_ASSERT_NOW(a_resize_phase, resized, phase_r == tnop_pkg::PH_SUBIAC, "resize outside IAC SE")
  `TNOP_ASSERT_NEXT(a_greet_once, step && greet, greeted_r && ext_r == tnop_pkg::EXT_ENABLED, "greet not latched")

endmodule

### src/telnet_option_parser.sv
// A byte is held in the input register; its result then waits in the result register for out_.
// Throughput: one byte per cycle unless a side stalls, which both registers allow.
// Each byte is parsed by one pass of logic in tnop_core between the two registers.
// Reset (rst_n low, synchronous): parser idle, size zero, option 200 pending, no beats held.
// Top level of the telnet option parser; depends on tnop_pkg and tnop_core.
module telnet_option_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_data,
  output logic        out_send_do_naws,
  output logic [1:0]  out_ext_status,
  output logic        out_greet_request,
  output logic        out_resized,
  output logic [15:0] out_win_width,
  output logic [15:0] out_win_height
);

  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                out_vld_r;
  tnop_pkg::tnop_res_t res;
  tnop_pkg::tnop_res_t res_r;
  logic                adv;

  // Parse the held byte whenever the result register is free or draining.
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  tnop_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_is_data       = res_r.is_data;
  assign out_send_do_naws  = res_r.send_do_naws;
  assign out_ext_status    = res_r.ext_status;
  assign out_greet_request = res_r.greet_request;
  assign out_resized       = res_r.resized;
  assign out_win_width     = res_r.win_width;
  assign out_win_height    = res_r.win_height;

endmodule

### sim/telnet_option_parser_checker.sv
// Checker for the telnet option parser: it watches the byte and result channels,
// predicts each result from a local copy of the parser state and compares it field by field.
// Depends on tnop_pkg for the byte codes, phase codes and the result struct.
module telnet_option_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_is_data,
  input  logic        out_send_do_naws,
  input  logic [1:0]  out_ext_status,
  input  logic        out_greet_request,
  input  logic        out_resized,
  input  logic [15:0] out_win_width,
  input  logic [15:0] out_win_height,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [2:0]  phase_q;
  logic [7:0]  verb_q;
  int unsigned sub_len;
  logic [7:0]  sub_buf [tnop_pkg::SUB_DEPTH];
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [1:0]  ext_q;
  logic        greeted_q;

  tnop_pkg::tnop_res_t expected_res_q [$];

  // One byte through the parser; updates the local state, returns the result beat.
  function automatic tnop_pkg::tnop_res_t parse_byte(input logic [7:0] b);
    tnop_pkg::tnop_res_t r;
    r = '0;
    case (phase_q)
      tnop_pkg::PH_IAC: begin
        if (b >= tnop_pkg::B_WILL && b <= tnop_pkg::B_DONT) begin
          verb_q  = b;
          phase_q = tnop_pkg::PH_OPT;
        end else if (b == tnop_pkg::B_SB) begin
          sub_len = 0;
          phase_q = tnop_pkg::PH_SUB;
        end else begin
          phase_q = tnop_pkg::PH_IDLE;   // IAC IAC and unknown commands are swallowed
        end
      end
      tnop_pkg::PH_OPT: begin
        if (b == tnop_pkg::OPT_NAWS) begin
          r.send_do_naws = 1'b1;
        end else if (b == tnop_pkg::OPT_EXT) begin
          if (verb_q == tnop_pkg::B_DO) begin
            ext_q = tnop_pkg::EXT_ENABLED;
            if (!greeted_q) begin
              r.greet_request = 1'b1;
              greeted_q       = 1'b1;
            end
          end else begin
            ext_q = tnop_pkg::EXT_REFUSED;
          end
        end
        phase_q = tnop_pkg::PH_IDLE;
      end
      tnop_pkg::PH_SUB: begin
        if (b == tnop_pkg::B_IAC) begin
          phase_q = tnop_pkg::PH_SUBIAC;
        end else if (sub_len < tnop_pkg::SUB_DEPTH) begin
          sub_buf[sub_len] = b;
          sub_len++;
        end
      end
      tnop_pkg::PH_SUBIAC: begin
        if (b == tnop_pkg::B_SE) begin
          if (sub_len >= tnop_pkg::NAWS_LEN && sub_buf[0] == tnop_pkg::OPT_NAWS) begin
            width_q   = {sub_buf[1], sub_buf[2]};
            height_q  = {sub_buf[3], sub_buf[4]};
            r.resized = 1'b1;
          end
          phase_q = tnop_pkg::PH_IDLE;
        end else begin
          phase_q = tnop_pkg::PH_SUB;    // stray command inside the payload is dropped
        end
      end
      default: begin
        if (b == tnop_pkg::B_IAC) begin
          phase_q = tnop_pkg::PH_IAC;
        end else begin
          r.is_data = 1'b1;
        end
      end
    endcase
    r.ext_status = ext_q;
    r.win_width  = width_q;
    r.win_height = height_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tnop_pkg::tnop_res_t want;
    if (!rst_n) begin
      phase_q    = tnop_pkg::PH_IDLE;
      verb_q     = '0;
      sub_len    = 0;
      width_q    = '0;
      height_q   = '0;
      ext_q      = tnop_pkg::EXT_PENDING;
      greeted_q  = 1'b0;
      mismatches = 0;
      expected_res_q.delete();
    end else begin
      // result first: a byte accepted at this edge cannot have its result out yet
      if (out_valid && out_ready) begin
        if (expected_res_q.size() == 0) begin
          $error("result beat with no byte outstanding");
          mismatches++;
        end else begin
          want = expected_res_q.pop_front();
          check_field("is_data",       16'(want.is_data),       16'(out_is_data));
          check_field("send_do_naws",  16'(want.send_do_naws),  16'(out_send_do_naws));
          check_field("ext_status",    16'(want.ext_status),    16'(out_ext_status));
          check_field("greet_request", 16'(want.greet_request), 16'(out_greet_request));
          check_field("resized",       16'(want.resized),       16'(out_resized));
          check_field("win_width",     want.win_width,          out_win_width);
          check_field("win_height",    want.win_height,         out_win_height);
        end
      end
      if (in_valid && in_ready)
        expected_res_q.push_back(parse_byte(in_rx_byte));
    end
    pending = expected_res_q.size();
  end

endmodule

### sim/telnet_option_parser_tb.sv
// Testbench top for the telnet option parser: clock, reset, byte stimulus and result stalls.
// Results are judged by telnet_option_parser_checker; depends on tnop_pkg and the RTL.
module telnet_option_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 950;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        out_is_data;
  logic        out_send_do_naws;
  logic [1:0]  out_ext_status;
  logic        out_greet_request;
  logic        out_resized;
  logic [15:0] out_win_width;
  logic [15:0] out_win_height;

  int          mismatches;
  int          pending;
  int unsigned cycle_n = 0;
  bit          tx_calm = 1'b0;

  always #10ns clk = ~clk;

  telnet_option_parser uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_data       (out_is_data),
    .out_send_do_naws  (out_send_do_naws),
    .out_ext_status    (out_ext_status),
    .out_greet_request (out_greet_request),
    .out_resized       (out_resized),
    .out_win_width     (out_win_width),
    .out_win_height    (out_win_height)
  );

  telnet_option_parser_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_data       (out_is_data),
    .out_send_do_naws  (out_send_do_naws),
    .out_ext_status    (out_ext_status),
    .out_greet_request (out_greet_request),
    .out_resized       (out_resized),
    .out_win_width     (out_win_width),
    .out_win_height    (out_win_height),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one byte, maybe after a short gap, and hold it until the beat is taken.
  task automatic send_byte(input logic [7:0] b);
    if (!tx_calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFE;
    return 8'($urandom_range(254));
  endfunction

  // Receiver: random stalls, one long hold-off, and a stretch that never stalls.
  initial begin
    int unsigned rx_cyc;
    rx_cyc = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (rx_cyc == 300) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        out_ready <= (rx_cyc >= 600 && rx_cyc < 900) || ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin
    logic [7:0]  directed [$];
    logic [7:0]  seq [$];
    logic [7:0]  junk;
    int unsigned sent_n;
    int unsigned kind;
    int unsigned len;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Data extremes, refuse then enable option 200, NAWS request, IAC IAC,
    // and a NAWS report with a stray command in the middle of its payload.
    directed = {8'h00, 8'hFE,
                tnop_pkg::B_IAC, tnop_pkg::B_WILL, tnop_pkg::OPT_EXT,
                tnop_pkg::B_IAC, tnop_pkg::B_DO, tnop_pkg::OPT_EXT,
                tnop_pkg::B_IAC, tnop_pkg::B_DONT, tnop_pkg::OPT_NAWS,
                tnop_pkg::B_IAC, tnop_pkg::B_IAC,
                tnop_pkg::B_IAC, tnop_pkg::B_SB, tnop_pkg::OPT_NAWS, 8'h80,
                tnop_pkg::B_IAC, 8'h07, 8'h01, 8'hFE, 8'h7F,
                tnop_pkg::B_IAC, tnop_pkg::B_SE};
    foreach (directed[i]) send_byte(directed[i]);

    sent_n = 0;
    while (sent_n < RANDOM_BYTES) begin
      seq.delete();
      kind = $urandom_range(99);
      if (kind < 25) begin
        repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(254)));
      end else if (kind < 50) begin
        seq.push_back(tnop_pkg::B_IAC);
        seq.push_back(8'($urandom_range(tnop_pkg::B_WILL, tnop_pkg::B_DONT)));
        len = $urandom_range(99);
        if (len < 35)      seq.push_back(tnop_pkg::OPT_NAWS);
        else if (len < 70) seq.push_back(tnop_pkg::OPT_EXT);
        else               seq.push_back(8'($urandom()));
      end else if (kind < 90) begin
        // subnegotiation: mostly NAWS reports, some short, long or foreign ones
        seq.push_back(tnop_pkg::B_IAC);
        seq.push_back(tnop_pkg::B_SB);
        seq.push_back(kind < 78 ? tnop_pkg::OPT_NAWS : 8'($urandom_range(254)));
        len = (kind < 72) ? 4 + $urandom_range(0, 2) : $urandom_range(0, 10);
        repeat (len) begin
          if ($urandom_range(99) < 10) begin
            junk = 8'($urandom());
            if (junk == tnop_pkg::B_SE) junk = tnop_pkg::B_SB;
            seq.push_back(tnop_pkg::B_IAC);
            seq.push_back(junk);
          end
          seq.push_back(payload_byte());
        end
        if ($urandom_range(99) >= 5) begin
          seq.push_back(tnop_pkg::B_IAC);
          seq.push_back(tnop_pkg::B_SE);
        end
      end else begin
        repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom()));
      end
      foreach (seq[i]) begin
        tx_calm = (sent_n >= 400 && sent_n < 650);
        send_byte(seq[i]);
        sent_n++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/tnop_pkg.sv
src/tnop_core.sv
src/telnet_option_parser.sv
sim/telnet_option_parser_checker.sv
sim/telnet_option_parser_tb.sv
